/* sv/mpcb_pkg.sv */
// shared types and constants for the mouse packet cursor and button decoder
package mpcb_pkg;

  // width of the stored cursor position
  localparam int POS_BITS = 10;
  // width of the cursor position fields on the result port
  localparam int CURSOR_W = 10;
  // width of the signed sums formed while moving the cursor
  localparam int SUM_W    = POS_BITS + 2;
  localparam int LIMIT_W  = 10;
  localparam int DELAY_W  = 8;
  localparam int CFG_W    = 10;

  localparam logic [7:0]         ACK_OK            = 8'hFA;
  localparam logic [LIMIT_W-1:0] X_LIMIT_RST       = 10'd360;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST       = 10'd240;
  localparam logic [DELAY_W-1:0] PRESS_DELAY_RST   = 8'd30;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 8'd5;

  typedef enum logic [1:0] {
    CFG_X_LIMIT      = 2'd0,
    CFG_Y_LIMIT      = 2'd1,
    CFG_PRESS_DELAY  = 2'd2,
    CFG_REPEAT_DELAY = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DOWN   = 2'd1,
    EV_CLICK  = 2'd2,
    EV_REPEAT = 2'd3
  } btn_event_e;

  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_PRESSED  = 2'd1,
    BTN_HOLDING  = 2'd2
  } btn_state_e;

  typedef struct packed {
    logic [7:0] ack_byte;
    logic [7:0] status_byte;
    logic [7:0] dx_byte;
    logic [7:0] dy_byte;
  } in_pkt_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_x;
    logic [CURSOR_W-1:0] cursor_y;
    logic                no_motion;
    logic                no_button;
    btn_state_e          left_state;
    btn_state_e          right_state;
    btn_event_e          left_event;
    btn_event_e          right_event;
  } out_res_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
    logic [DELAY_W-1:0] press_delay;
    logic [DELAY_W-1:0] repeat_delay;
  } cfg_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_x;
    logic [CURSOR_W-1:0] cursor_y;
    logic                no_motion;
  } mot_res_t;

  typedef struct packed {
    logic       no_button;
    btn_state_e left_state;
    btn_state_e right_state;
    btn_event_e left_event;
    btn_event_e right_event;
  } btn_res_t;

endpackage

/* sv/mpcb_motion.sv */
// cursor position tracking with clamping and the no-motion flag
module mpcb_motion (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  mpcb_pkg::in_pkt_t pkt_i,
  input  mpcb_pkg::cfg_t    cfg_i,
  output mpcb_pkg::mot_res_t res_o
);
  import mpcb_pkg::*;

  logic [POS_BITS-1:0]    pos_x_q, pos_x_d;
  logic [POS_BITS-1:0]    pos_y_q, pos_y_d;
  logic                   idle_q, idle_d;
  logic signed [8:0]      dx9, dy9;
  logic signed [SUM_W-1:0] sum_x, sum_y, lim_x, lim_y;
  logic                   ack_ok, moved;

  assign ack_ok = (pkt_i.ack_byte == ACK_OK);
  assign dx9    = {pkt_i.status_byte[4], pkt_i.dx_byte};
  assign dy9    = {pkt_i.status_byte[5], pkt_i.dy_byte};
  assign moved  = (dx9 != 9'sd0) || (dy9 != 9'sd0);

  always_comb begin
    sum_x = SUM_W'({1'b0, pos_x_q}) + SUM_W'(dx9);
    sum_y = SUM_W'({1'b0, pos_y_q}) - SUM_W'(dy9);
    lim_x = SUM_W'({1'b0, cfg_i.x_limit});
    lim_y = SUM_W'({1'b0, cfg_i.y_limit});
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    idle_d  = idle_q;
    if (ack_ok) begin
      if (moved) begin
        idle_d = 1'b0;
        if (sum_x < 0) begin
          pos_x_d = '0;
        end else if (sum_x > lim_x) begin
          pos_x_d = POS_BITS'(cfg_i.x_limit);
        end else begin
          pos_x_d = POS_BITS'(sum_x);
        end
        if (sum_y < 0) begin
          pos_y_d = '0;
        end else if (sum_y > lim_y) begin
          pos_y_d = POS_BITS'(cfg_i.y_limit);
        end else begin
          pos_y_d = POS_BITS'(sum_y);
        end
      end else begin
        idle_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      idle_q  <= 1'b0;
    end else if (step_i) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      idle_q  <= idle_d;
    end
  end

  assign res_o.cursor_x  = CURSOR_W'(pos_x_d);
  assign res_o.cursor_y  = CURSOR_W'(pos_y_d);
  assign res_o.no_motion = idle_d;

endmodule

/* sv/mpcb_buttons.sv */
// button edge detection, shared hold counter and repeat events
module mpcb_buttons (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [1:0]         btn_i,
  input  mpcb_pkg::cfg_t     cfg_i,
  output mpcb_pkg::btn_res_t res_o
);
  import mpcb_pkg::*;

  logic [1:0]         last_q, rel_q, prs_q, hld_q;
  logic [1:0]         rel_d, prs_d, hld_d;
  logic [DELAY_W-1:0] cnt_q, cnt_d;
  logic               idle_q, idle_d;
  btn_event_e         ev [2];
  btn_state_e         st [2];

  // left is handled before right, both share the hold counter
  always_comb begin
    rel_d  = rel_q;
    prs_d  = prs_q;
    hld_d  = hld_q;
    cnt_d  = cnt_q;
    idle_d = idle_q;
    ev[0]  = EV_NONE;
    ev[1]  = EV_NONE;
    if (btn_i != last_q) begin
      idle_d = 1'b0;
      for (int b = 0; b < 2; b++) begin
        if (!btn_i[b]) begin
          rel_d[b] = 1'b1;
          if (prs_d[b]) ev[b] = EV_CLICK;
          prs_d[b] = 1'b0;
          hld_d[b] = 1'b0;
        end else if (!prs_d[b] && !hld_d[b]) begin
          prs_d[b] = 1'b1;
          rel_d[b] = 1'b0;
          ev[b]    = EV_DOWN;
          // only reload when the other button is not mid-countdown
          if (!prs_d[1-b] || hld_d[1-b]) cnt_d = cfg_i.press_delay;
        end
      end
    end else begin
      if (rel_q == 2'b11) idle_d = 1'b1;
      for (int b = 0; b < 2; b++) begin
        if (prs_d[b]) begin
          if (cnt_d != '0) begin
            cnt_d = cnt_d - DELAY_W'(1);
          end else begin
            if (!hld_d[b]) hld_d[b] = 1'b1;
            else ev[b] = EV_REPEAT;
            cnt_d = cfg_i.repeat_delay;
          end
        end
      end
    end
    for (int b = 0; b < 2; b++) begin
      if (hld_d[b])      st[b] = BTN_HOLDING;
      else if (prs_d[b]) st[b] = BTN_PRESSED;
      else               st[b] = BTN_RELEASED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      rel_q  <= '0;
      prs_q  <= '0;
      hld_q  <= '0;
      cnt_q  <= '0;
      idle_q <= 1'b0;
    end else if (step_i) begin
      last_q <= btn_i;
      rel_q  <= rel_d;
      prs_q  <= prs_d;
      hld_q  <= hld_d;
      cnt_q  <= cnt_d;
      idle_q <= idle_d;
    end
  end

  assign res_o.no_button   = idle_d;
  assign res_o.left_state  = st[0];
  assign res_o.right_state = st[1];
  assign res_o.left_event  = ev[0];
  assign res_o.right_event = ev[1];

endmodule

/* sv/mouse_packet_cursor_buttons_top.sv */
// top level of the mouse packet cursor and button decoder
// an accepted request has its result on the output register in the next cycle
// throughput: one request per cycle while the held result is not stalled, limited only by the single result register
// a new request is taken while the held result is being taken in the same cycle
// reset: asynchronous active low, clears position, button state, counter and
// restores the default limits and delays; the output register comes up empty
module mouse_packet_cursor_buttons_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mpcb_pkg::in_pkt_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mpcb_pkg::out_res_t        out_data_o,
  input  logic                      cfg_we_i,
  input  mpcb_pkg::cfg_idx_e        cfg_idx_i,
  input  logic [mpcb_pkg::CFG_W-1:0] cfg_data_i
);
  import mpcb_pkg::*;

  cfg_t     cfg_q;
  out_res_t res_q;
  logic     res_valid_q;
  logic     step;
  mot_res_t mot_res;
  btn_res_t btn_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_limit      <= X_LIMIT_RST;
      cfg_q.y_limit      <= Y_LIMIT_RST;
      cfg_q.press_delay  <= PRESS_DELAY_RST;
      cfg_q.repeat_delay <= REPEAT_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_LIMIT:      cfg_q.x_limit      <= LIMIT_W'(cfg_data_i);
        CFG_Y_LIMIT:      cfg_q.y_limit      <= LIMIT_W'(cfg_data_i);
        CFG_PRESS_DELAY:  cfg_q.press_delay  <= DELAY_W'(cfg_data_i);
        CFG_REPEAT_DELAY: cfg_q.repeat_delay <= DELAY_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_stall_o = res_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  mpcb_motion u_motion (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pkt_i  (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (mot_res)
  );

  mpcb_buttons u_buttons (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .btn_i  (in_data_i.status_byte[1:0]),
    .cfg_i  (cfg_q),
    .res_o  (btn_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.cursor_x    <= mot_res.cursor_x;
      res_q.cursor_y    <= mot_res.cursor_y;
      res_q.no_motion   <= mot_res.no_motion;
      res_q.no_button   <= btn_res.no_button;
      res_q.left_state  <= btn_res.left_state;
      res_q.right_state <= btn_res.right_state;
      res_q.left_event  <= btn_res.left_event;
      res_q.right_event <= btn_res.right_event;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

/* sv/mpcb_checker.sv */
// port-level checks for the mouse packet decoder and their binding
module mpcb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mpcb_pkg::out_res_t out_data_o
);
  import mpcb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // every accepted request shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no result");

  // a down event leaves the button pressed, a click leaves it released
  a_event_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.left_event != EV_DOWN || out_data_o.left_state == BTN_PRESSED) &&
      (out_data_o.left_event != EV_CLICK || out_data_o.left_state == BTN_RELEASED) &&
      (out_data_o.right_event != EV_DOWN || out_data_o.right_state == BTN_PRESSED) &&
      (out_data_o.right_event != EV_CLICK || out_data_o.right_state == BTN_RELEASED))
    else $error("button event does not match button state");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_button |->
      out_data_o.left_state == BTN_RELEASED && out_data_o.right_state == BTN_RELEASED)
    else $error("no-button flag with a button down");

endmodule

bind mouse_packet_cursor_buttons_top mpcb_checker u_mpcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/testbench.sv */
// self-checking testbench for the mouse packet cursor and button decoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpcb_pkg::*;

  // predicts cursor and button results per packet and checks them in order
  class packet_scoreboard;
    logic [LIMIT_W-1:0] x_lim, y_lim;
    logic [DELAY_W-1:0] press_dly, repeat_dly;
    int pos_x, pos_y;
    bit [1:0] btn_last, released, pressed, holding;
    int hold_cnt;
    bit motion_idle, button_idle;
    out_res_t expected_q[$];
    int errors, checked, downs, clicks, repeats;

    function new();
      x_lim = X_LIMIT_RST;
      y_lim = Y_LIMIT_RST;
      press_dly = PRESS_DELAY_RST;
      repeat_dly = REPEAT_DELAY_RST;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_X_LIMIT: x_lim = val[LIMIT_W-1:0];
        CFG_Y_LIMIT: y_lim = val[LIMIT_W-1:0];
        CFG_PRESS_DELAY: press_dly = val[DELAY_W-1:0];
        CFG_REPEAT_DELAY: repeat_dly = val[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_axis(int v, int lim);
      if (v < 0) return 0;
      if (v > lim) return lim;
      return v;
    endfunction

    // level change of one button; the hold counter is shared
    function void button_edge(int b, bit down, inout btn_event_e ev);
      int other;
      other = 1 - b;
      if (!down) begin
        released[b] = 1'b1;
        if (pressed[b]) begin
          ev = EV_CLICK;
          clicks++;
        end
        pressed[b] = 1'b0;
        holding[b] = 1'b0;
      end else if (!pressed[b] && !holding[b]) begin
        pressed[b] = 1'b1;
        released[b] = 1'b0;
        ev = EV_DOWN;
        downs++;
        if (!pressed[other] || holding[other]) hold_cnt = press_dly;
      end
    endfunction

    function void hold_tick(int b, inout btn_event_e ev);
      if (!pressed[b]) return;
      if (hold_cnt > 0) begin
        hold_cnt--;
        return;
      end
      if (!holding[b]) holding[b] = 1'b1;
      else begin
        ev = EV_REPEAT;
        repeats++;
      end
      hold_cnt = repeat_dly;
    endfunction

    function btn_state_e level_of(int b);
      if (holding[b]) return BTN_HOLDING;
      if (pressed[b]) return BTN_PRESSED;
      return BTN_RELEASED;
    endfunction

    function void note_request(in_pkt_t p);
      int dx, dy;
      btn_event_e lev, rev;
      out_res_t r;
      lev = EV_NONE;
      rev = EV_NONE;
      if (p.ack_byte == ACK_OK) begin
        dx = p.status_byte[4] ? int'(p.dx_byte) - 256 : int'(p.dx_byte);
        dy = p.status_byte[5] ? int'(p.dy_byte) - 256 : int'(p.dy_byte);
        if (dx != 0 || dy != 0) begin
          motion_idle = 1'b0;
          // screen y grows downward, mouse dy grows upward
          pos_x = clamp_axis(pos_x + dx, int'(x_lim));
          pos_y = clamp_axis(pos_y - dy, int'(y_lim));
        end else begin
          motion_idle = 1'b1;
        end
      end
      if (p.status_byte[1:0] != btn_last) begin
        button_idle = 1'b0;
        btn_last = p.status_byte[1:0];
        button_edge(0, btn_last[0], lev);
        button_edge(1, btn_last[1], rev);
      end else begin
        if (released == 2'b11) button_idle = 1'b1;
        hold_tick(0, lev);
        hold_tick(1, rev);
      end
      r.cursor_x = pos_x[CURSOR_W-1:0];
      r.cursor_y = pos_y[CURSOR_W-1:0];
      r.no_motion = motion_idle;
      r.no_button = button_idle;
      r.left_state = level_of(0);
      r.right_state = level_of(1);
      r.left_event = lev;
      r.right_event = rev;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(out_res_t got);
      out_res_t want;
      if (expected_q.size() == 0) begin
        report("result with no request waiting", 0, 0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.cursor_x !== want.cursor_x)
        report("cursor_x", 32'(got.cursor_x), 32'(want.cursor_x));
      if (got.cursor_y !== want.cursor_y)
        report("cursor_y", 32'(got.cursor_y), 32'(want.cursor_y));
      if (got.no_motion !== want.no_motion)
        report("no_motion", 32'(got.no_motion), 32'(want.no_motion));
      if (got.no_button !== want.no_button)
        report("no_button", 32'(got.no_button), 32'(want.no_button));
      if (got.left_state !== want.left_state)
        report("left_state", 32'(got.left_state), 32'(want.left_state));
      if (got.right_state !== want.right_state)
        report("right_state", 32'(got.right_state), 32'(want.right_state));
      if (got.left_event !== want.left_event)
        report("left_event", 32'(got.left_event), 32'(want.left_event));
      if (got.right_event !== want.right_event)
        report("right_event", 32'(got.right_event), 32'(want.right_event));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_pkt_t          in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_res_t         out_data_o;
  logic             cfg_we_i = 1'b0;
  cfg_idx_e         cfg_idx_i = CFG_X_LIMIT;
  logic [CFG_W-1:0] cfg_data_i = '0;

  packet_scoreboard sb = new();
  bit   idle_on = 1'b1;
  bit   stall_on = 1'b1;
  logic holdoff_req = 1'b0;
  int   sent;
  int   holdoffs;

  // limit and delay settings of the random phases
  int phase_x[6] = '{360, 1023, 0, 511, 200, 1023};
  int phase_y[6] = '{240, 1023, 0, 3, 700, 0};
  int phase_p[6] = '{30, 0, 255, 1, 4, 3};
  int phase_r[6] = '{5, 0, 255, 2, 0, 255};
  int phase_n[6] = '{240, 240, 300, 240, 240, 240};

  // ack, status, dx, dy
  logic [31:0] directed_pkts[25] = '{
    32'hFA000000, 32'hFA007F00, 32'hFA00FF00, 32'hFA100000, 32'hFA200000,
    32'hFA0000FF, 32'h00004040, 32'hFF308080, 32'hFA30FFFF, 32'hFA010500,
    32'hFA010000, 32'hFA010000, 32'hFA010000, 32'hFA010000, 32'hFA010000,
    32'hFA030000, 32'hFA030000, 32'hFA030000, 32'hFA020000, 32'hFA000000,
    32'hFA000000, 32'hFA020000, 32'hFA030000, 32'h12000000, 32'hFACC0000
  };

  mouse_packet_cursor_buttons_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // result side: random stall, or a long hold-off when asked
  initial begin : receiver
    int hold_cycles;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req <= 1'b0;
        hold_cycles = $urandom_range(40, 80);
        out_stall_i <= 1'b1;
        holdoffs++;
        repeat (hold_cycles) @(posedge clk_i);
      end else begin
        out_stall_i <= stall_on && ($urandom_range(0, 99) < 22);
      end
    end
  end

  task automatic send_packet(input in_pkt_t p);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 22) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(p);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] xl, yl, pd, rd);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_X_LIMIT;
    cfg_data_i <= xl;
    sb.set_reg(CFG_X_LIMIT, xl);
    @(posedge clk_i);
    cfg_idx_i <= CFG_Y_LIMIT;
    cfg_data_i <= yl;
    sb.set_reg(CFG_Y_LIMIT, yl);
    @(posedge clk_i);
    cfg_idx_i <= CFG_PRESS_DELAY;
    cfg_data_i <= pd;
    sb.set_reg(CFG_PRESS_DELAY, pd);
    @(posedge clk_i);
    cfg_idx_i <= CFG_REPEAT_DELAY;
    cfg_data_i <= rd;
    sb.set_reg(CFG_REPEAT_DELAY, rd);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    in_pkt_t    p;
    int         run_left;
    logic [1:0] held_btn;
    run_left = 0;
    held_btn = 2'b00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short delays so holding and repeat show up within a few packets
    apply_settings(CFG_W'(100), CFG_W'(50), CFG_W'(2), CFG_W'(1));
    foreach (directed_pkts[i]) send_packet(in_pkt_t'(directed_pkts[i]));
    wait_drained();
    repeat (2) @(posedge clk_i);

    for (int ph = 0; ph < 6; ph++) begin
      apply_settings(CFG_W'(phase_x[ph]), CFG_W'(phase_y[ph]),
                     CFG_W'(phase_p[ph]), CFG_W'(phase_r[ph]));
      idle_on = (ph != 3);
      stall_on = (ph != 3);
      for (int i = 0; i < phase_n[ph]; i++) begin
        // buttons are held for runs, mostly short, some long enough to repeat
        if (run_left == 0) begin
          held_btn = 2'($urandom_range(0, 3));
          run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 320)
                                                 : $urandom_range(1, 8);
        end
        run_left--;
        p.ack_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ACK_OK;
        p.status_byte = 8'($urandom);
        p.status_byte[1:0] = ($urandom_range(0, 19) == 0) ? 2'($urandom) : held_btn;
        if ($urandom_range(0, 4) == 0) begin
          p.dx_byte = 8'h00;
          p.dy_byte = 8'h00;
          p.status_byte[5:4] = 2'b00;
        end else begin
          p.dx_byte = 8'($urandom);
          p.dy_byte = 8'($urandom);
        end
        if (ph == 1 && i == 60) holdoff_req <= 1'b1;
        if (ph == 4 && i == 100) wait_drained();
        send_packet(p);
      end
      wait_drained();
      repeat (2) @(posedge clk_i);
    end

    repeat (4) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report("requests left without result", sb.expected_q.size(), 0);
    $display("run covered %0d packets over 7 register settings, %0d results checked",
             sent, sb.checked);
    $display("button events: %0d down, %0d click, %0d repeat; %0d long receiver hold-offs",
             sb.downs, sb.clicks, sb.repeats, holdoffs);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("timeout waiting for requests or results");
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/mpcb_pkg.sv
sv/mpcb_motion.sv
sv/mpcb_buttons.sv
sv/mouse_packet_cursor_buttons_top.sv
sv/mpcb_checker.sv
tb/sv/testbench.sv
